// File: rtl/ita_pkg.sv
// shared types, constants and helpers for the integer to ascii formatter
// no dependencies; imported by ita_cell and integer_to_ascii_formatter
package ita_pkg;

    // digit chain geometry
    localparam int NUM_CELLS = 11;
    localparam int DIGIT_W   = 4;
    localparam int VALUE_W   = 32;
    localparam int CNT_W     = 5;
    localparam int HEX_DIGITS = VALUE_W / 4;

    // last cycle index of the decimal conversion pass
    localparam logic [CNT_W-1:0] DABBLE_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [CNT_W-1:0] CELL_COUNT  = CNT_W'(NUM_CELLS);

    // format selector codes
    localparam logic [1:0] FMT_UDEC = 2'd0;
    localparam logic [1:0] FMT_SDEC = 2'd1;
    localparam logic [1:0] FMT_OCT  = 2'd2;
    localparam logic [1:0] FMT_HEX  = 2'd3;

    // ascii codes
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // operation applied to every cell of the chain in the same cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_PFX_A,
        ST_PFX_B,
        ST_DIGITS,
        ST_SUFFIX
    } state_t;

    typedef logic [DIGIT_W-1:0] digit_t;

    // digit loaded straight into cell idx for octal and hex, zero otherwise
    function automatic digit_t load_digit(input logic [1:0] cmd,
                                          input logic [VALUE_W-1:0] value,
                                          input int idx);
        logic [VALUE_W:0] wide;
        digit_t d;
        wide = {1'b0, value};
        d    = '0;
        case (cmd)
            FMT_OCT:
            begin
                d = {1'b0, 3'(wide >> (3 * idx))};
            end
            FMT_HEX:
            begin
                if (idx < HEX_DIGITS)
                begin
                    d = 4'(value >> (4 * idx));
                end
            end
            default:
            begin
                d = '0;
            end
        endcase
        return d;
    endfunction

endpackage

// File: rtl/ita_cell.sv
// one digit cell of the chain: load, shift-add-3 conversion step, digit shift, or hold
// depends on ita_pkg
module ita_cell (
    input  logic              clk,
    input  ita_pkg::cell_op_t op,
    input  ita_pkg::digit_t   load_val,
    input  logic              carry_in,
    input  ita_pkg::digit_t   prev_digit,
    output ita_pkg::digit_t   digit,
    output logic              carry_out
);
    import ita_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    // add three when the digit would overflow on doubling
    always_comb
    begin
        adj = (digit_reg >= digit_t'(5)) ? digit_reg + digit_t'(3) : digit_reg;
    end

    // next digit per chain operation
    always_comb
    begin
        case (op)
            CELL_LOAD:   digit_next = load_val;
            CELL_DABBLE: digit_next = {adj[DIGIT_W-2:0], carry_in};
            CELL_SHIFT:  digit_next = prev_digit;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign carry_out = adj[DIGIT_W-1];

endmodule

// File: rtl/integer_to_ascii_formatter.sv
// integer to ascii formatter: decimal, signed decimal, octal, hex text output
// octal/hex go straight to the prefix; decimal first runs a shift-add-3 pass over all
// 32 value bits; all then shift the chain once per digit emitted or leading zero skipped
// throughput: one character per cycle, but none while stalled, skipping a leading zero or
// in the decimal pass; a new item is accepted only after the last character is emitted
// reset: rst_n async active low clears sequencer and output valid; needs ita_pkg, ita_cell
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_out
    output logic        m_axis_tlast    // last
);
    import ita_pkg::*;

    state_t state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;
    logic               started_reg, started_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] sh_reg, sh_next;
    logic               ovalid_reg, ovalid_next;
    logic [7:0]         ochar_reg, ochar_next;
    logic               olast_reg, olast_next;

    logic     accept;
    logic     can_emit;
    logic     skip;
    logic     emit;
    logic     emit_last;
    logic [7:0] emit_char;
    cell_op_t cell_op;
    digit_t   top_digit;
    logic     in_neg;

    digit_t digits [NUM_CELLS];
    logic   carries [NUM_CELLS];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign can_emit  = !ovalid_reg || m_axis_tready;
    assign top_digit = digits[NUM_CELLS-1];
    assign in_neg    = (s_axis_tuser == FMT_SDEC) && s_axis_tdata[VALUE_W-1];
    assign skip      = !started_reg && (top_digit == '0) && (cnt_reg != CNT_W'(1));

    // digit chain
    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            digit_t ld;
            logic   cin;
            digit_t prev;
            assign ld = load_digit(s_axis_tuser, s_axis_tdata, gi);
            if (gi == 0)
            begin : g_first
                assign cin  = sh_reg[VALUE_W-1];
                assign prev = '0;
            end
            else
            begin : g_rest
                assign cin  = carries[gi-1];
                assign prev = digits[gi-1];
            end
            ita_cell u_cell (
                .clk        (clk),
                .op         (cell_op),
                .load_val   (ld),
                .carry_in   (cin),
                .prev_digit (prev),
                .digit      (digits[gi]),
                .carry_out  (carries[gi])
            );
        end
    endgenerate

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        cell_op       = CELL_HOLD;
        emit          = 1'b0;
        emit_char     = CHR_ZERO;
        emit_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    cell_op = CELL_LOAD;
                end
            end
            ST_DABBLE:
            begin
                cell_op = CELL_DABBLE;
            end
            ST_PFX_A:
            begin
                emit      = 1'b1;
                emit_char = (cmd_reg == FMT_SDEC) ? CHR_MINUS : CHR_ZERO;
                emit_last = (cmd_reg == FMT_OCT) && zero_reg;
            end
            ST_PFX_B:
            begin
                emit      = 1'b1;
                emit_char = CHR_X;
            end
            ST_DIGITS:
            begin
                emit      = !skip;
                emit_char = DIGIT_CHARS[top_digit];
                emit_last = (cnt_reg == CNT_W'(1)) && (cmd_reg != FMT_UDEC);
                if (skip || can_emit)
                begin
                    cell_op = CELL_SHIFT;
                end
            end
            ST_SUFFIX:
            begin
                emit      = 1'b1;
                emit_char = CHR_SPACE;
                emit_last = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == FMT_UDEC || s_axis_tuser == FMT_SDEC)
                    begin
                        state_next = ST_DABBLE;
                    end
                    else
                    begin
                        state_next = ST_PFX_A;
                    end
                end
            end
            ST_DABBLE:
            begin
                if (cnt_reg == DABBLE_LAST)
                begin
                    state_next = neg_reg ? ST_PFX_A : ST_DIGITS;
                end
            end
            ST_PFX_A:
            begin
                if (can_emit)
                begin
                    if (cmd_reg == FMT_HEX)
                    begin
                        state_next = ST_PFX_B;
                    end
                    else if (cmd_reg == FMT_OCT && zero_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIGITS;
                    end
                end
            end
            ST_PFX_B:
            begin
                if (can_emit)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (!skip && can_emit && cnt_reg == CNT_W'(1))
                begin
                    state_next = (cmd_reg == FMT_UDEC) ? ST_SUFFIX : ST_IDLE;
                end
            end
            ST_SUFFIX:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers next values
    always_comb
    begin
        cmd_next     = cmd_reg;
        neg_next     = neg_reg;
        zero_next    = zero_reg;
        sh_next      = sh_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;

        if (accept)
        begin
            cmd_next  = s_axis_tuser;
            neg_next  = in_neg;
            zero_next = (s_axis_tdata == '0);
            sh_next   = in_neg ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
            cnt_next  = '0;
        end
        else if (state_reg == ST_DABBLE)
        begin
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (state_reg == ST_DIGITS && (skip || can_emit))
        begin
            cnt_next     = cnt_reg - CNT_W'(1);
            started_next = started_reg || !skip;
        end

        // arm the digit count on entry to the digit phase
        if (state_next == ST_DIGITS && state_reg != ST_DIGITS)
        begin
            cnt_next     = CELL_COUNT;
            started_next = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg && !m_axis_tready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        if (emit && can_emit)
        begin
            ovalid_next = 1'b1;
            ochar_next  = emit_char;
            olast_next  = emit_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        sh_reg    <= sh_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;

    // a new item only arrives behind the final character of the previous one
    a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && m_axis_tvalid) |-> m_axis_tlast)
        else $error("item accepted while a non-final character is pending");

    // digit count stays within the chain during the digit phase
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGITS) |-> (cnt_reg != '0 && cnt_reg <= CELL_COUNT))
        else $error("digit count out of range");

    // a 32-bit decimal value never reaches the top cell
    a_top_cell_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DABBLE && cnt_reg == DABBLE_LAST) |=> (top_digit == '0))
        else $error("decimal conversion overflowed the digit chain");

    // output character is never dropped under back pressure
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_axis_tready) |=> ovalid_reg)
        else $error("pending character lost");

endmodule
